@@ hw/rtl/orse_pkg.sv @@
// Shared types and constants for the 1-Wire search ROM engine.
// No dependencies; imported by orse_step and onewire_rom_search_engine_top.
package orse_pkg;

   localparam int CRC_BYTES = 7;
   localparam int ROM_BITS = 64;
   localparam int CRC_LSB = CRC_BYTES * 8;

   localparam logic [1:0] ACT_NEW_SEARCH = 2'd0;
   localparam logic [1:0] ACT_START_PASS = 2'd1;
   localparam logic [1:0] ACT_BIT_PAIR = 2'd2;

   localparam logic [2:0] STATUS_BUSY = 3'd0;
   localparam logic [2:0] STATUS_FOUND = 3'd1;
   localparam logic [2:0] STATUS_CRC_MISMATCH = 3'd2;
   localparam logic [2:0] STATUS_OTHER_FAMILY = 3'd3;
   localparam logic [2:0] STATUS_NO_RESPONSE = 3'd4;
   localparam logic [2:0] STATUS_NO_PRESENCE = 3'd5;
   localparam logic [2:0] STATUS_SEARCH_DONE = 3'd6;
   localparam logic [2:0] STATUS_NOT_IN_PASS = 3'd7;

   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam logic [7:0] FAMILY_RESET = 8'h28;
   localparam logic [6:0] START_POSITION = 7'd1;
   localparam logic [6:0] END_POSITION = 7'd65;
   localparam logic [6:0] FAMILY_LIMIT = 7'd9;
   localparam logic [6:0] CRC_LAST_POSITION = 7'(CRC_LSB);

   // register word index of wanted_family
   localparam logic REG_WANTED_FAMILY = 1'b0;

   typedef struct packed {
      logic [ROM_BITS-1:0] rom_bits;
      logic [6:0]          last_discrepancy;
      logic [6:0]          last_zero_pos;
      logic [6:0]          bit_position;
      logic [3:0]          family_mark;
      logic [7:0]          crc_acc;
      logic                done_flag;
      logic                in_pass;
   } search_state_type;

   typedef struct packed {
      logic                direction;
      logic                direction_valid;
      logic                pass_end;
      logic [2:0]          status;
      logic [ROM_BITS-1:0] rom_id;
      logic                search_done;
      logic [3:0]          family_discrepancy;
   } result_type;

endpackage

@@ hw/rtl/orse_step.sv @@
// Next-state and result logic for one search transaction.
// Depends on orse_pkg; purely combinational, registered by the top level.
module orse_step (
   input  orse_pkg::search_state_type cur,
   input  logic [7:0]                 wanted_family,
   input  logic [1:0]                 action,
   input  logic                       presence,
   input  logic                       id_bit,
   input  logic                       complement_bit,
   output orse_pkg::search_state_type nxt,
   output orse_pkg::result_type       res
);
   import orse_pkg::*;

   logic [6:0] pos;
   logic [5:0] idx;
   logic       dir;
   logic       mix;
   logic [6:0] pos_next;

   assign pos = cur.bit_position;
   assign idx = pos[5:0] - 6'd1;
   assign pos_next = pos + 7'd1;

   always_comb begin
      nxt = cur;
      dir = 1'b0;
      mix = 1'b0;
      res.direction = 1'b0;
      res.direction_valid = 1'b0;
      res.pass_end = 1'b0;
      res.status = STATUS_BUSY;

      unique case (action)
         ACT_NEW_SEARCH: begin
            nxt.rom_bits = '0;
            nxt.last_discrepancy = '0;
            nxt.last_zero_pos = '0;
            nxt.bit_position = START_POSITION;
            nxt.family_mark = '0;
            nxt.crc_acc = '0;
            nxt.done_flag = 1'b0;
            nxt.in_pass = 1'b0;
            res.status = STATUS_NOT_IN_PASS;
         end
         ACT_START_PASS: begin
            if (cur.done_flag) begin
               res.status = STATUS_SEARCH_DONE;
            end else if (!presence) begin
               nxt.done_flag = 1'b1;
               nxt.in_pass = 1'b0;
               res.pass_end = 1'b1;
               res.status = STATUS_NO_PRESENCE;
            end else begin
               nxt.in_pass = 1'b1;
               nxt.bit_position = START_POSITION;
               nxt.last_zero_pos = '0;
               nxt.crc_acc = '0;
            end
         end
         ACT_BIT_PAIR: begin
            if (!cur.in_pass) begin
               res.status = STATUS_NOT_IN_PASS;
            end else if (id_bit && complement_bit) begin
               // no device answered: close the pass
               nxt.last_discrepancy = cur.last_zero_pos;
               nxt.done_flag = cur.done_flag || (cur.last_zero_pos == '0);
               nxt.in_pass = 1'b0;
               res.pass_end = 1'b1;
               res.status = STATUS_NO_RESPONSE;
            end else begin
               if (!id_bit && !complement_bit) begin
                  // discrepancy: follow the old path, branch at the last one
                  if (pos < cur.last_discrepancy) begin
                     dir = cur.rom_bits[idx];
                  end else begin
                     dir = (pos == cur.last_discrepancy);
                  end
                  if (!dir) begin
                     nxt.last_zero_pos = pos;
                     if (pos < FAMILY_LIMIT) begin
                        nxt.family_mark = pos[3:0];
                     end
                  end
               end else begin
                  dir = id_bit;
               end
               nxt.rom_bits[idx] = dir;
               if (pos <= CRC_LAST_POSITION) begin
                  mix = cur.crc_acc[0] ^ dir;
                  nxt.crc_acc = {1'b0, cur.crc_acc[7:1]} ^ (mix ? CRC_POLY : 8'h00);
               end
               nxt.bit_position = pos_next;
               res.direction = dir;
               res.direction_valid = 1'b1;
               if (pos_next >= END_POSITION) begin
                  if (nxt.crc_acc != nxt.rom_bits[CRC_LSB +: 8]) begin
                     res.status = STATUS_CRC_MISMATCH;
                  end else if (nxt.rom_bits[7:0] != wanted_family) begin
                     res.status = STATUS_OTHER_FAMILY;
                  end else begin
                     res.status = STATUS_FOUND;
                  end
                  nxt.last_discrepancy = nxt.last_zero_pos;
                  nxt.done_flag = cur.done_flag || (nxt.last_zero_pos == '0);
                  nxt.in_pass = 1'b0;
                  res.pass_end = 1'b1;
               end
            end
         end
         default: begin
            res.status = cur.in_pass ? STATUS_BUSY : STATUS_NOT_IN_PASS;
         end
      endcase

      res.rom_id = nxt.rom_bits;
      res.search_done = nxt.done_flag;
      res.family_discrepancy = nxt.family_mark;
   end

endmodule

@@ hw/rtl/onewire_rom_search_engine_top.sv @@
// Result valid the cycle after its request; one transaction per cycle while rsp_ready holds.
// Search state updates at the request handshake; the result sits in one output register,
// and a new request is taken whenever that register is empty or being drained.
// Synchronous active-high reset clears the search state (bit_position to 1) and the result valid,
// and sets wanted_family to 0x28. Depends on orse_pkg and orse_step.
module onewire_rom_search_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic        req_presence,
   input  logic        req_id_bit,
   input  logic        req_complement_bit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_direction,
   output logic        rsp_direction_valid,
   output logic        rsp_pass_end,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_rom_id,
   output logic        rsp_search_done,
   output logic [3:0]  rsp_family_discrepancy,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import orse_pkg::*;

   search_state_type state_ff, state_in, state_step;
   result_type       rsp_ff, rsp_in, step_res;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       wanted_family_ff, wanted_family_in;
   logic             req_fire;

   orse_step u_step (
      .cur            (state_ff),
      .wanted_family  (wanted_family_ff),
      .action         (req_action),
      .presence       (req_presence),
      .id_bit         (req_id_bit),
      .complement_bit (req_complement_bit),
      .nxt            (state_step),
      .res            (step_res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         state_in = state_step;
         rsp_in = step_res;
         rsp_valid_in = 1'b1;
      end
   end

   assign pready = 1'b1;

   always_comb begin
      wanted_family_in = wanted_family_ff;
      if (psel && penable && pwrite && paddr[2] == REG_WANTED_FAMILY) begin
         wanted_family_in = pwdata[7:0];
      end
   end

   assign prdata = (paddr[2] == REG_WANTED_FAMILY) ? {24'd0, wanted_family_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bits <= '0;
         state_ff.last_discrepancy <= '0;
         state_ff.last_zero_pos <= '0;
         state_ff.bit_position <= START_POSITION;
         state_ff.family_mark <= '0;
         state_ff.crc_acc <= '0;
         state_ff.done_flag <= 1'b0;
         state_ff.in_pass <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wanted_family_ff <= FAMILY_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wanted_family_ff <= wanted_family_in;
      end
   end

   // result payload holds while stalled
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_direction = rsp_ff.direction;
   assign rsp_direction_valid = rsp_ff.direction_valid;
   assign rsp_pass_end = rsp_ff.pass_end;
   assign rsp_status = rsp_ff.status;
   assign rsp_rom_id = rsp_ff.rom_id;
   assign rsp_search_done = rsp_ff.search_done;
   assign rsp_family_discrepancy = rsp_ff.family_discrepancy;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for onewire_rom_search_engine_top: drives search traffic
// from a modeled bus of devices, predicts every result and compares it field by field.
// Depends on orse_pkg and the onewire_rom_search_engine_top RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import orse_pkg::*;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [2:0] FAMILY_ADDR = 3'(4 * REG_WANTED_FAMILY);
   // stop starting new traffic once this many transactions went out in total
   localparam int ITEM_TARGET = 1000;
   localparam int MAX_DEVICES = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_NEW_SEARCH;
   logic        req_presence = 1'b0;
   logic        req_id_bit = 1'b0;
   logic        req_complement_bit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_direction;
   logic        rsp_direction_valid;
   logic        rsp_pass_end;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_rom_id;
   logic        rsp_search_done;
   logic [3:0]  rsp_family_discrepancy;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   search_state_type engine_state;
   logic [7:0]       family_setting;
   result_type       pending_results[$];
   int               stall_pct = 24;
   int               mismatch_count = 0;
   int               sent_count = 0;
   int               family_writes = 0;
   int               status_seen[8];

   onewire_rom_search_engine_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_presence(req_presence),
      .req_id_bit(req_id_bit),
      .req_complement_bit(req_complement_bit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_direction(rsp_direction),
      .rsp_direction_valid(rsp_direction_valid),
      .rsp_pass_end(rsp_pass_end),
      .rsp_status(rsp_status),
      .rsp_rom_id(rsp_rom_id),
      .rsp_search_done(rsp_search_done),
      .rsp_family_discrepancy(rsp_family_discrepancy),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one step of the reflected CRC-8, shared by the predictor and the device builder
   function automatic logic [7:0] crc_shift(input logic [7:0] acc, input logic b);
      logic mix;
      mix = acc[0] ^ b;
      acc = acc >> 1;
      if (mix) begin
         acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   function automatic void close_search_pass();
      engine_state.last_discrepancy = engine_state.last_zero_pos;
      if (engine_state.last_discrepancy == 7'd0) begin
         engine_state.done_flag = 1'b1;
      end
      engine_state.in_pass = 1'b0;
   endfunction

   function automatic result_type advance_search(input logic [1:0] act, input logic pres,
                                                 input logic idb, input logic cmpb);
      result_type r;
      logic [6:0] pos;
      logic [5:0] idx;
      logic       dir;
      logic [7:0] got_crc;
      r = '0;
      case (act)
         ACT_NEW_SEARCH: begin
            engine_state = '0;
            engine_state.bit_position = START_POSITION;
            r.status = STATUS_NOT_IN_PASS;
         end
         ACT_START_PASS: begin
            if (engine_state.done_flag) begin
               r.status = STATUS_SEARCH_DONE;
            end else if (!pres) begin
               engine_state.done_flag = 1'b1;
               engine_state.in_pass = 1'b0;
               r.pass_end = 1'b1;
               r.status = STATUS_NO_PRESENCE;
            end else begin
               engine_state.in_pass = 1'b1;
               engine_state.bit_position = START_POSITION;
               engine_state.last_zero_pos = 7'd0;
               engine_state.crc_acc = 8'd0;
               r.status = STATUS_BUSY;
            end
         end
         ACT_BIT_PAIR: begin
            if (!engine_state.in_pass) begin
               r.status = STATUS_NOT_IN_PASS;
            end else if (idb && cmpb) begin
               close_search_pass();
               r.pass_end = 1'b1;
               r.status = STATUS_NO_RESPONSE;
            end else begin
               pos = engine_state.bit_position;
               idx = 6'(pos - 7'd1);
               if (!idb && !cmpb) begin
                  // discrepancy: follow the previous path below the last discrepancy
                  if (pos < engine_state.last_discrepancy) begin
                     dir = engine_state.rom_bits[idx];
                  end else begin
                     dir = (pos == engine_state.last_discrepancy);
                  end
                  if (!dir) begin
                     engine_state.last_zero_pos = pos;
                     if (pos < FAMILY_LIMIT) begin
                        engine_state.family_mark = pos[3:0];
                     end
                  end
               end else begin
                  dir = idb;
               end
               engine_state.rom_bits[idx] = dir;
               if (pos <= CRC_LAST_POSITION) begin
                  engine_state.crc_acc = crc_shift(engine_state.crc_acc, dir);
               end
               r.direction = dir;
               r.direction_valid = 1'b1;
               engine_state.bit_position = pos + 7'd1;
               if (engine_state.bit_position >= END_POSITION) begin
                  got_crc = engine_state.rom_bits[CRC_LSB +: 8];
                  if (engine_state.crc_acc != got_crc) begin
                     r.status = STATUS_CRC_MISMATCH;
                  end else if (engine_state.rom_bits[7:0] != family_setting) begin
                     r.status = STATUS_OTHER_FAMILY;
                  end else begin
                     r.status = STATUS_FOUND;
                  end
                  close_search_pass();
                  r.pass_end = 1'b1;
               end else begin
                  r.status = STATUS_BUSY;
               end
            end
         end
         default: begin
            r.status = engine_state.in_pass ? STATUS_BUSY : STATUS_NOT_IN_PASS;
         end
      endcase
      r.rom_id = engine_state.rom_bits;
      r.search_done = engine_state.done_flag;
      r.family_discrepancy = engine_state.family_mark;
      return r;
   endfunction

   // Present one request, hold it until accepted, then record its expected result.
   task automatic send_item(input logic [1:0] act, input logic pres, input logic idb,
                            input logic cmpb, output result_type predicted);
      if ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_action <= act;
      req_presence <= pres;
      req_id_bit <= idb;
      req_complement_bit <= cmpb;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = advance_search(act, pres, idb, cmpb);
      pending_results.insert(pending_results.size(), predicted);
      status_seen[predicted.status]++;
      sent_count++;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_results.size() != 0 && guard < 5000);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         mismatch_count++;
         pending_results.delete();
      end
      repeat (2) @(posedge clock);
   endtask

   // Write wanted_family over the register port, then read it back.
   task automatic write_family(input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= FAMILY_ADDR;
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      family_setting = value;
      family_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== value) begin
         $error("wanted_family readback: expected 0x%0h, got 0x%0h", value, prdata[7:0]);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Run one full search over a bus of ndev modeled devices, with rare disturbances.
   task automatic run_search(input int ndev);
      logic [63:0] roms[MAX_DEVICES];
      bit          active[MAX_DEVICES];
      logic [7:0]  crc;
      logic        idb;
      logic        cmpb;
      int          passes;
      result_type  r;
      for (int d = 0; d < ndev; d++) begin
         roms[d] = {$urandom, $urandom};
         roms[d][7:0] = $urandom_range(1) ? family_setting : 8'($urandom);
         crc = 8'd0;
         for (int b = 0; b < CRC_LSB; b++) begin
            crc = crc_shift(crc, roms[d][b]);
         end
         // spoil the CRC of about one device in five
         roms[d][63:56] = ($urandom_range(4) == 0) ? crc ^ 8'($urandom_range(1, 255)) : crc;
      end
      send_item(ACT_NEW_SEARCH, 1'($urandom), 1'($urandom), 1'($urandom), r);
      passes = 0;
      while (passes < 2 * ndev + 6) begin
         passes++;
         send_item(ACT_START_PASS, (ndev != 0) || 1'($urandom), 1'($urandom),
                   1'($urandom), r);
         if (r.status != STATUS_BUSY) begin
            break;
         end
         for (int d = 0; d < ndev; d++) begin
            active[d] = 1'b1;
         end
         for (int b = 0; b < ROM_BITS; b++) begin
            idb = 1'b1;
            cmpb = 1'b1;
            for (int d = 0; d < ndev; d++) begin
               if (active[d]) begin
                  idb &= roms[d][b];
                  cmpb &= ~roms[d][b];
               end
            end
            if ($urandom_range(199) == 0) begin
               // drop every device off the bus mid pass
               idb = 1'b1;
               cmpb = 1'b1;
            end else if ($urandom_range(199) == 0) begin
               send_item(ACT_IGNORED, 1'($urandom), 1'($urandom), 1'($urandom), r);
            end
            send_item(ACT_BIT_PAIR, 1'($urandom), idb, cmpb, r);
            if (r.pass_end) begin
               break;
            end
            for (int d = 0; d < ndev; d++) begin
               if (roms[d][b] != r.direction) begin
                  active[d] = 1'b0;
               end
            end
         end
         if (r.search_done) begin
            break;
         end
      end
      if ($urandom_range(1)) begin
         send_item(ACT_START_PASS, 1'($urandom), 1'($urandom), 1'($urandom), r);
      end
   endtask

   task automatic test_directed_cases();
      result_type r;
      send_item(ACT_BIT_PAIR, 1'b0, 1'b1, 1'b0, r);
      send_item(ACT_IGNORED, 1'b1, 1'b1, 1'b1, r);
      send_item(ACT_START_PASS, 1'b0, 1'b0, 1'b0, r);
      send_item(ACT_START_PASS, 1'b1, 1'b0, 1'b0, r);
      send_item(ACT_NEW_SEARCH, 1'b1, 1'b1, 1'b1, r);
      send_item(ACT_START_PASS, 1'b1, 1'b1, 1'b1, r);
      send_item(ACT_IGNORED, 1'b0, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b1, 1'b1, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b0, 1'b0, 1'b1, r);
      // abandon the running pass and start over
      send_item(ACT_START_PASS, 1'b1, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b0, 1'b1, 1'b1, r);
      send_item(ACT_START_PASS, 1'b1, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
      send_item(ACT_BIT_PAIR, 1'b1, 1'b1, 1'b1, r);
      send_item(ACT_BIT_PAIR, 1'b1, 1'b0, 1'b0, r);
      send_item(ACT_START_PASS, 1'b1, 1'b0, 1'b0, r);
      send_item(ACT_NEW_SEARCH, 1'b0, 1'b0, 1'b0, r);
      wait_drained();
   endtask

   task automatic test_default_family_search();
      run_search(1);
      run_search(3);
      run_search(0);
      wait_drained();
   endtask

   task automatic test_family_register();
      logic [7:0] values[3];
      values = '{8'h00, 8'hFF, FAMILY_RESET};
      foreach (values[i]) begin
         write_family(values[i]);
         // no idling on either side for the first setting
         stall_pct = (i == 0) ? 0 : 24;
         run_search($urandom_range(1, 3));
         wait_drained();
      end
      stall_pct = 24;
   endtask

   task automatic test_random_traffic();
      int         pick;
      result_type r;
      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(9);
         if (pick < 7) begin
            run_search($urandom_range(0, MAX_DEVICES));
         end else if (pick < 9) begin
            repeat ($urandom_range(5, 15)) begin
               send_item($urandom_range(1) ? ACT_BIT_PAIR : 2'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), r);
            end
         end else begin
            wait_drained();
            write_family($urandom_range(3) == 0 ? FAMILY_RESET : 8'($urandom));
         end
      end
      wait_drained();
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Check each result transaction against the oldest prediction; randomize rsp_ready.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no prediction pending");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("direction", want.direction, rsp_direction);
               check_field("direction_valid", want.direction_valid, rsp_direction_valid);
               check_field("pass_end", want.pass_end, rsp_pass_end);
               check_field("status", want.status, rsp_status);
               check_field("rom_id", want.rom_id, rsp_rom_id);
               check_field("search_done", want.search_done, rsp_search_done);
               check_field("family_discrepancy", want.family_discrepancy,
                           rsp_family_discrepancy);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      engine_state = '0;
      engine_state.bit_position = START_POSITION;
      family_setting = FAMILY_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_default_family_search();
      test_family_register();
      test_random_traffic();
      $display("Sent %0d request transactions over %0d family settings.",
               sent_count, family_writes + 1);
      $display("Pass ends: %0d found, %0d bad CRC, %0d other family, %0d aborted, %0d absent.",
               status_seen[STATUS_FOUND], status_seen[STATUS_CRC_MISMATCH],
               status_seen[STATUS_OTHER_FAMILY], status_seen[STATUS_NO_RESPONSE],
               status_seen[STATUS_NO_PRESENCE]);
      if (mismatch_count == 0) begin
         $display("onewire_rom_search_engine_top verification clean");
      end else begin
         $display("onewire_rom_search_engine_top verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("onewire_rom_search_engine_top verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/orse_pkg.sv
hw/rtl/orse_step.sv
hw/rtl/onewire_rom_search_engine_top.sv
tb/tb.sv
